// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the hash table RTL.
// Each macro expands to one labelled concurrent assertion on clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// Plain invariant checked on every edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: label");
`endif

// File: hw/rtl/lpht_pkg.sv
// Package for the linear-probe hash table: widths, codes, murmur constants.
// No dependencies.
package lpht_pkg;
  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY) + 1;
  localparam int KEY_W      = 64;
  localparam int VAL_IN_W   = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT = 33;

  // Entry passed from the hash front end to the probe engine.
  typedef struct packed {
    logic [1:0]          op;
    logic [KEY_W-1:0]    key;
    logic [VAL_IN_W-1:0] value_handle;
    logic [IDX_W-1:0]    home;
  } job_t;
endpackage

// File: hw/rtl/lpht_if.sv
// Valid/ready channel interfaces for the hash table.
// Depends on lpht_pkg for field widths.
interface lpht_req_if;
  import lpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [KEY_W-1:0]    key;
  logic [VAL_IN_W-1:0] value_handle;
  modport source (output valid, output op, output key, output value_handle, input ready);
  modport sink   (input valid, input op, input key, input value_handle, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [VAL_IN_W-1:0] value_out;
  modport source (output valid, output status, output value_out, input ready);
  modport sink   (input valid, input status, input value_out, output ready);
endinterface

// File: hw/rtl/lpht_hash.sv
// Front end: pipelined murmur3 finaliser computing each key's home slot.
// Depends on lpht_pkg. Five stages; each multiply stage has three parallel 32x32 products.
module lpht_hash (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpht_pkg::job_t     in_job,
  output logic               out_valid,
  input  logic               out_ready,
  output lpht_pkg::job_t     out_job
);
  import lpht_pkg::*;

  // Only the low bits of each product are needed; a 64x64 low product is
  // split as lo*lo (full) plus the low halves of the two cross terms.
  logic [4:0]  v_r;
  job_t        j_r [5];
  logic [63:0] k_r [5];
  logic [31:0] pa_r, pb_r;
  logic [31:0] pa2_r, pb2_r;
  logic        adv;

  assign adv = !v_r[4] || out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[4];
  always_comb begin
    out_job = j_r[4];
    out_job.home = k_r[4][IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_r[0] <= in_job;
      k_r[0] <= in_job.key ^ (in_job.key >> MIX_SHIFT);
      // stage 1: partial products with C1
      j_r[1] <= j_r[0];
      k_r[1] <= {32'd0, k_r[0][31:0]} * {32'd0, MIX_C1[31:0]};
      pa_r   <= k_r[0][63:32] * MIX_C1[31:0];
      pb_r   <= k_r[0][31:0] * MIX_C1[63:32];
      // stage 2: sum and mix
      j_r[2] <= j_r[1];
      k_r[2] <= (k_r[1] + {pa_r[31:0] + pb_r[31:0], 32'd0})
              ^ ((k_r[1] + {pa_r[31:0] + pb_r[31:0], 32'd0}) >> MIX_SHIFT);
      // stage 3: partial products with C2
      j_r[3] <= j_r[2];
      k_r[3] <= {32'd0, k_r[2][31:0]} * {32'd0, MIX_C2[31:0]};
      j_r[4] <= j_r[3];
      k_r[4] <= (k_r[3] + {pa2_r + pb2_r, 32'd0})
              ^ ((k_r[3] + {pa2_r + pb2_r, 32'd0}) >> MIX_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa2_r <= k_r[2][63:32] * MIX_C2[31:0];
      pb2_r <= k_r[2][31:0] * MIX_C2[63:32];
    end
  end
endmodule

// File: hw/rtl/lpht_fifo.sv
// Short job queue between the hash front end and the probe engine.
// Depends on lpht_pkg for job_t.
module lpht_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lpht_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output lpht_pkg::job_t out_job
);
  import lpht_pkg::*;
  `include "assert_macros.svh"

  job_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       push, pop;

  assign in_ready  = cnt_r != 3'd4;
  assign out_valid = cnt_r != 3'd0;
  assign out_job   = q_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_job;
  end

  `ASSERT_ALWAYS(a_fifo_bound, cnt_r <= 3'd4)
  `ASSERT_ALWAYS(a_fifo_ptrs, wp_r == rp_r + cnt_r[1:0])
endmodule

// File: hw/rtl/lpht_probe.sv
// Back end: probe engine walking the slot memories, one job at a time.
// Depends on lpht_pkg. Runs a clearing pass over the marks after reset.
module lpht_probe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  lpht_pkg::job_t job,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output logic [1:0]     rsp_status,
  output logic [lpht_pkg::VAL_IN_W-1:0] rsp_value
);
  import lpht_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [KEY_W-1:0]      keys_m  [CAPACITY];
  logic [VALUE_BITS-1:0] vals_m  [CAPACITY];
  logic [1:0]            marks_m [CAPACITY];

  logic [2:0]            state_r, state_nxt;
  job_t                  job_r;
  logic [IDX_W-1:0]      idx_r, tgt_r;
  logic [CNT_W-1:0]      n_r, live_r, tomb_r;
  logic                  have_del_r;
  logic [KEY_W-1:0]      rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [1:0]            rd_mark_r;
  logic [1:0]            st_r;
  logic [VAL_IN_W-1:0]   vo_r;
  logic                  full;
  logic                  hit;
  logic                  last;

  // Write port control, decided in S_CLEAR and S_EVAL.
  logic                  wr_en, wr_kv;
  logic [IDX_W-1:0]      wr_idx;
  logic [1:0]            wr_mark;

  assign full = (({2'b00, live_r} + {2'b00, tomb_r}) << 2)
              >= (CNT_W + 2)'(CAPACITY * 3);
  assign hit  = rd_mark_r == MARK_USED && rd_key_r == job_r.key;
  assign last = n_r == CNT_W'(CAPACITY - 1);

  assign job_ready  = state_r == S_IDLE;
  assign rsp_valid  = state_r == S_RESP;
  assign rsp_status = st_r;
  assign rsp_value  = vo_r;

  always_ff @(posedge clk) begin
    rd_key_r  <= keys_m[idx_r];
    rd_val_r  <= vals_m[idx_r];
    rd_mark_r <= marks_m[idx_r];
    if (wr_en) marks_m[wr_idx] <= wr_mark;
    if (wr_kv) begin
      keys_m[wr_idx] <= job_r.key;
      vals_m[wr_idx] <= job_r.value_handle[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    wr_en = 1'b0;
    wr_kv = 1'b0;
    wr_idx = idx_r;
    wr_mark = MARK_EMPTY;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (idx_r == IDX_W'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (job_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_READ;
        if (job_r.op == OP_INSERT) begin
          if (full || hit) begin
            state_nxt = S_RESP;
          end else if (rd_mark_r == MARK_EMPTY || (last && have_del_r)
                       || (last && rd_mark_r == MARK_DELETED)) begin
            state_nxt = S_RESP;
            wr_en = 1'b1;
            wr_kv = 1'b1;
            wr_mark = MARK_USED;
            wr_idx = have_del_r ? tgt_r : idx_r;
          end else if (last) begin
            state_nxt = S_RESP;
          end
        end else if (job_r.op == OP_LOOKUP || job_r.op == OP_REMOVE) begin
          if (hit) begin
            state_nxt = S_RESP;
            if (job_r.op == OP_REMOVE) begin
              wr_en = 1'b1;
              wr_mark = MARK_DELETED;
            end
          end else if (rd_mark_r == MARK_EMPTY || last) begin
            state_nxt = S_RESP;
          end
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: if (rsp_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r <= '0;
      live_r <= '0;
      tomb_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: idx_r <= idx_r + 1'b1;
        S_IDLE: if (job_valid) begin
          job_r <= job;
          idx_r <= job.home;
          n_r <= '0;
          have_del_r <= 1'b0;
        end
        S_EVAL: begin
          if (state_nxt == S_READ) begin
            idx_r <= idx_r + 1'b1;
            n_r <= n_r + 1'b1;
            if (rd_mark_r == MARK_DELETED && !have_del_r) begin
              have_del_r <= 1'b1;
              tgt_r <= idx_r;
            end
          end else begin
            vo_r <= '0;
            if (job_r.op == OP_INSERT) begin
              if (full) st_r <= ST_FULL;
              else if (hit) st_r <= ST_DUP;
              else if (wr_kv) begin
                st_r <= ST_OK;
                live_r <= live_r + 1'b1;
                if (have_del_r || rd_mark_r == MARK_DELETED) tomb_r <= tomb_r - 1'b1;
              end else st_r <= ST_FULL;
            end else if (hit && (job_r.op == OP_LOOKUP || job_r.op == OP_REMOVE)) begin
              st_r <= ST_OK;
              if (job_r.op == OP_LOOKUP) vo_r <= VAL_IN_W'(rd_val_r);
              else begin
                live_r <= live_r - 1'b1;
                tomb_r <= tomb_r + 1'b1;
              end
            end else st_r <= ST_NOTFOUND;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, {1'b0, live_r} + {1'b0, tomb_r} <= (CNT_W + 1)'(CAPACITY))
  `ASSERT_IMPL(a_resp_holds, state_r == S_RESP && !rsp_ready, state_nxt == S_RESP)
  `ASSERT_IMPL(a_walk_bound, state_r == S_READ || state_r == S_EVAL,
               n_r < CNT_W'(CAPACITY))
endmodule

// File: hw/rtl/linear_probe_hash_table_unit.sv
// Top level of the linear-probe hash table: hash front end, job queue, probe engine.
// Depends on lpht_pkg, lpht_if, lpht_hash, lpht_fifo and lpht_probe.
// With only the home slot probed, an accepted input beat passes through the rest
// of the five-stage hash pipeline and the job queue; the probe engine then takes
// the job, reads the slot from the slot memories, decides, and offers the response
// beat. Each further slot adds another read and decision, up to all CAPACITY slots.
// The probe engine handles one item at a time (take, read, decide, answer);
// meanwhile the hash pipeline and the queue hold up to nine further items. After
// reset the slot marks are cleared in a pass over all CAPACITY slots before the
// first item is probed.
module linear_probe_hash_table_unit (
  input logic        clk,
  input logic        rst_n,
  lpht_req_if.sink   in_ch,
  lpht_rsp_if.source out_ch
);
  import lpht_pkg::*;

  job_t in_job, h_job, q_job;
  logic h_valid, h_ready, q_valid, q_ready;

  always_comb begin
    in_job.op = in_ch.op;
    in_job.key = in_ch.key;
    in_job.value_handle = in_ch.value_handle;
    in_job.home = '0;
  end

  lpht_hash u_hash (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_job(in_job),
    .out_valid(h_valid), .out_ready(h_ready), .out_job(h_job)
  );

  lpht_fifo u_fifo (
    .clk, .rst_n,
    .in_valid(h_valid), .in_ready(h_ready), .in_job(h_job),
    .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
  );

  lpht_probe u_probe (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready),
    .rsp_status(out_ch.status), .rsp_value(out_ch.value_out)
  );
endmodule

// File: sim/tb_linear_probe_hash_table_unit.sv
// Self-checking testbench for the linear-probe hash table unit.
// Depends on lpht_pkg, lpht_if and the RTL of linear_probe_hash_table_unit.
// A behavioural map model predicts every response beat, checked in order.
module tb_linear_probe_hash_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam int TAIL_ITEMS  = 80;
  localparam int DRAIN_WAIT  = 2 * CAPACITY + 64;
  localparam int POOL_SIZE   = 48;

  // Operation code with no meaning; the block answers not found.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]          op;
    logic [KEY_W-1:0]    key;
    logic [VAL_IN_W-1:0] val;
    bit                  drain;
  } req_t;

  typedef struct {
    logic [1:0]          status;
    logic [VAL_IN_W-1:0] value_out;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lpht_req_if in_if();
  lpht_rsp_if out_if();

  linear_probe_hash_table_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  req_t pending_reqs[$];
  rsp_t due_results[$];
  int   errors = 0;

  // Map model state.
  logic [1:0]          map_mark[CAPACITY];
  logic [KEY_W-1:0]    map_key[CAPACITY];
  logic [VAL_IN_W-1:0] map_val[CAPACITY];
  int                  n_live = 0;
  int                  n_dead = 0;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  function automatic logic [IDX_W-1:0] slot_of(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = k;
    h = h ^ (h >> MIX_SHIFT);
    h = h * MIX_C1;
    h = h ^ (h >> MIX_SHIFT);
    h = h * MIX_C2;
    h = h ^ (h >> MIX_SHIFT);
    return h[IDX_W-1:0];
  endfunction

  // Returns the slot holding k, or -1.
  function automatic int find_key(logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] idx;
    idx = slot_of(k);
    for (int n = 0; n < CAPACITY; n++) begin
      if (map_mark[idx] == MARK_USED && map_key[idx] == k) return int'(idx);
      if (map_mark[idx] == MARK_EMPTY) return -1;
      idx = idx + 1'b1;
    end
    return -1;
  endfunction

  function automatic logic [1:0] map_insert(logic [KEY_W-1:0] k, logic [VAL_IN_W-1:0] v);
    logic [IDX_W-1:0] idx;
    int target;
    bit have_del;
    bit have_empty;
    target = 0;
    have_del = 0;
    have_empty = 0;
    if ((n_live + n_dead) * 4 >= CAPACITY * 3) return ST_FULL;
    idx = slot_of(k);
    for (int n = 0; n < CAPACITY; n++) begin
      if (map_mark[idx] == MARK_USED && map_key[idx] == k) return ST_DUP;
      if (map_mark[idx] == MARK_EMPTY) begin
        if (!have_del) target = int'(idx);
        have_empty = 1;
        break;
      end
      if (map_mark[idx] == MARK_DELETED && !have_del) begin
        have_del = 1;
        target = int'(idx);
      end
      idx = idx + 1'b1;
    end
    if (!have_empty && !have_del) return ST_FULL;
    if (map_mark[target] == MARK_DELETED) n_dead--;
    map_mark[target] = MARK_USED;
    map_key[target]  = k;
    map_val[target]  = v;
    n_live++;
    return ST_OK;
  endfunction

  function automatic rsp_t hash_map_step(req_t r);
    rsp_t res;
    int s;
    res.status = ST_NOTFOUND;
    res.value_out = '0;
    case (r.op)
      OP_INSERT: begin
        res.status = map_insert(r.key, r.val);
      end
      OP_LOOKUP: begin
        s = find_key(r.key);
        if (s >= 0) begin
          res.status = ST_OK;
          res.value_out = map_val[s];
        end
      end
      OP_REMOVE: begin
        s = find_key(r.key);
        if (s >= 0) begin
          map_mark[s] = MARK_DELETED;
          map_val[s] = '0;
          n_live--;
          n_dead++;
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic push_req(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_IN_W-1:0] v,
                          bit drain = 0);
    req_t r;
    r.op = op;
    r.key = k;
    r.val = v;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VAL_IN_W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] key_at_slot(logic [IDX_W-1:0] home);
    logic [KEY_W-1:0] k;
    k = rand_key();
    while (slot_of(k) != home) k = rand_key();
    return k;
  endfunction

  task automatic push_mixed(int count);
    logic [KEY_W-1:0] k;
    int pick;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 9) == 0) ? rand_key() : key_pool[$urandom_range(0, POOL_SIZE-1)];
      pick = $urandom_range(0, 99);
      if (pick < 40)      push_req(OP_INSERT, k, rand_val());
      else if (pick < 75) push_req(OP_LOOKUP, k, rand_val());
      else if (pick < 95) push_req(OP_REMOVE, k, rand_val());
      else                push_req(OP_UNUSED, k, rand_val());
    end
  endtask

  // Driver: one decision per edge, so valid gets a single assignment per step.
  int gap_left = 0;
  always @(posedge clk) begin
    req_t r;
    bit fire;
    bit calm;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      fire = in_if.valid && in_if.ready;
      calm = pending_reqs.size() < TAIL_ITEMS;
      if (fire) begin
        r.op = in_if.op;
        r.key = in_if.key;
        r.val = in_if.value_handle;
        due_results.push_back(hash_map_step(r));
      end
      if (!in_if.valid || fire) begin
        if (gap_left > 0 && !calm) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (pending_reqs[0].drain && due_results.size() != 0) begin
          // Hold off until every outstanding response beat has come back.
          in_if.valid <= 1'b0;
        end else begin
          r = pending_reqs.pop_front();
          in_if.valid        <= 1'b1;
          in_if.op           <= r.op;
          in_if.key          <= r.key;
          in_if.value_handle <= r.val;
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
        end
      end
    end
  end

  // Monitor and response-side back-pressure.
  int stall_left = 0;
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected response beat status=%0d value=%h",
                   $time, out_if.status, out_if.value_out);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_if.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_if.status);
            errors++;
          end
          if (out_if.value_out !== want.value_out) begin
            $display("%0t: value_out expected %h actual %h",
                     $time, want.value_out, out_if.value_out);
            errors++;
          end
        end
      end
      if (pending_reqs.size() < TAIL_ITEMS) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] c0, c1, c2, c3;
    in_if.valid = 1'b0;
    in_if.op = OP_INSERT;
    in_if.key = '0;
    in_if.value_handle = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      map_mark[i] = MARK_EMPTY;
      map_key[i] = '0;
      map_val[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand_key();

    // Keys sharing the last slot, so their probe runs wrap round to slot zero.
    c0 = key_at_slot(IDX_W'(CAPACITY - 1));
    c1 = key_at_slot(IDX_W'(CAPACITY - 1));
    c2 = key_at_slot(IDX_W'(CAPACITY - 1));
    c3 = key_at_slot(IDX_W'(CAPACITY - 1));

    push_req(OP_LOOKUP, '0, '0);
    push_req(OP_INSERT, '0, '1);
    push_req(OP_INSERT, '1, '0);
    push_req(OP_INSERT, '0, 32'h1234_5678);
    push_req(OP_LOOKUP, '0, '0);
    push_req(OP_LOOKUP, '1, '1);
    push_req(OP_REMOVE, '1, '0);
    push_req(OP_REMOVE, '1, '0);
    push_req(OP_LOOKUP, '1, '0);
    push_req(OP_UNUSED, '1, '1);
    push_req(OP_INSERT, c0, 32'hA5A5_5A5A);
    push_req(OP_INSERT, c1, 32'h5A5A_A5A5);
    push_req(OP_INSERT, c2, 32'hFFFF_0000);
    push_req(OP_REMOVE, c1, '0);
    push_req(OP_LOOKUP, c2, '0);
    push_req(OP_INSERT, c2, 32'h0000_FFFF);
    push_req(OP_INSERT, c3, 32'h0F0F_F0F0);
    push_req(OP_LOOKUP, c3, '0);
    push_req(OP_LOOKUP, c1, '0);
    push_req(OP_REMOVE, c0, '0);
    push_req(OP_LOOKUP, c2, '0);

    push_req(OP_LOOKUP, key_pool[0], '0, 1);
    push_mixed(30);

    // Fill with fresh keys until the load limit answers table full.
    push_req(OP_LOOKUP, c3, '0, 1);
    for (int i = 0; i < 770; i++) begin
      if ($urandom_range(0, 49) == 0)
        push_req(OP_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE-1)], rand_val());
      push_req(OP_INSERT, rand_key(), rand_val());
    end

    push_req(OP_LOOKUP, key_pool[1], '0, 1);
    push_mixed(20);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || due_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// File: linear_probe_hash_table_unit.f
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_if.sv
hw/rtl/lpht_hash.sv
hw/rtl/lpht_fifo.sv
hw/rtl/lpht_probe.sv
hw/rtl/linear_probe_hash_table_unit.sv
sim/tb_linear_probe_hash_table_unit.sv
